// ===== hw/rtl/sdhcd_pkg.sv =====
package sdhcd_pkg;

  localparam int BASE_W = 28;
  localparam int REQ_W = 32;
  localparam int CODE_W = 10;
  localparam int WORD_W = 16;
  localparam int DIV_W = 11;
  localparam int CNT_W = $clog2(BASE_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_V3 = 2'd1;

  // Command to the shared divider.
  typedef struct packed {
    logic              start;
    logic [BASE_W-1:0] dividend;
    logic [BASE_W-1:0] divisor;
  } div_req_t;

  // Status from the shared divider.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BASE_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/sdhcd_div.sv =====
module sdhcd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdhcd_pkg::div_req_t req_i,
  output sdhcd_pkg::div_rsp_t rsp_o
);

  localparam int W = sdhcd_pkg::BASE_W;
  localparam logic [sdhcd_pkg::CNT_W-1:0] LAST = sdhcd_pkg::CNT_W'(W - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [sdhcd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]                rem_q, quo_q, dvs_q;
  logic [W:0]                  rem_sh, diff;
  logic                        ge;

  // One quotient bit per cycle, restoring form.
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hw/rtl/sd_host_clock_divider_top.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------------------
// request  | in        | in_valid_i / in_stall_o | requested_hz_i
// result   | out       | out_valid_o/out_stall_i | divider_code_o, clock_control_word_o,
//          |           |                         | achieved_hz_o
// config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// A request at or above the base clock goes from its acceptance straight to the final
// state and then to the output register. A request below it makes two passes through
// the shared restoring divider (one quotient bit per cycle), for the search quotient and
// for base over the divider, with a selection state between, then the final state.
// Reset clears the configuration, the sequencer and the output valid flag.
// A stalled result stays in the output register while the next transaction
// computes; the new result waits in the final state until that register frees.
module sd_host_clock_divider_top #(
  parameter int V3_DIVIDER_CAP     = 2046,
  parameter int LEGACY_DIVIDER_CAP = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sdhcd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sdhcd_pkg::BASE_W-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sdhcd_pkg::REQ_W-1:0]          requested_hz_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sdhcd_pkg::CODE_W-1:0]         divider_code_o,
  output logic [sdhcd_pkg::WORD_W-1:0]         clock_control_word_o,
  output logic [sdhcd_pkg::BASE_W-1:0]         achieved_hz_o
);

  localparam int BW = sdhcd_pkg::BASE_W;
  localparam int DW = sdhcd_pkg::DIV_W;

  // The search stops at the first even value, or the first power of two,
  // at or above its cap. Both fit the 11-bit divider.
  localparam logic [DW-1:0] V3_STOP = DW'(V3_DIVIDER_CAP + (V3_DIVIDER_CAP % 2));
  localparam logic [DW-1:0] LEGACY_STOP = DW'(1 << $clog2(LEGACY_DIVIDER_CAP));

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_QUOT = 5'b00010,
    ST_SEL  = 5'b00100,
    ST_ACH  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  // Smallest power of two at or above v, for v no larger than 256.
  function automatic logic [8:0] pow2_ceil(input logic [8:0] v);
    logic [8:0] r;
    r = 9'd256;
    for (int i = 8; i >= 0; i--) begin
      if ((9'd1 << i) >= v) begin
        r = 9'd1 << i;
      end
    end
    return r;
  endfunction

  state_e                      state_q, state_d;
  logic [BW-1:0]               base_q;
  logic                        v3_q;
  logic [DW-1:0]               div_q;
  logic [BW-1:0]               ach_q;
  logic                        out_valid_q, out_valid_d;
  logic [sdhcd_pkg::CODE_W-1:0] code_q;
  logic [sdhcd_pkg::CODE_W-1:0] code_next;
  logic [BW-1:0]               ach_out_q;
  logic                        accept;
  logic                        at_or_above;
  logic                        load_out;
  logic [BW:0]                 d0;
  logic [DW-1:0]               sel_div;
  sdhcd_pkg::div_req_t         div_req;
  sdhcd_pkg::div_rsp_t         div_rsp;

  sdhcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The request is ready only while the sequencer idles.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign at_or_above = requested_hz_i >= {{(sdhcd_pkg::REQ_W - BW){1'b0}}, base_q};

  // floor(base / d) <= req holds exactly when d > floor(base / (req + 1)),
  // so the smallest qualifying divider is that quotient plus one, rounded
  // up to the next even value or power of two and limited by the stop value.
  assign d0 = {1'b0, div_rsp.quotient} + 1'b1;

  always_comb begin
    if (v3_q) begin
      if (d0 > {{(BW + 1 - DW){1'b0}}, V3_STOP}) begin
        sel_div = V3_STOP;
      end else begin
        sel_div = d0[DW-1:0] + {{(DW - 1){1'b0}}, d0[0]};
      end
    end else begin
      if (d0 > {{(BW + 1 - DW){1'b0}}, LEGACY_STOP}) begin
        sel_div = LEGACY_STOP;
      end else begin
        sel_div = {{(DW - 9){1'b0}}, pow2_ceil(d0[8:0])};
      end
    end
  end

  // Sequencer: quotient for the search, selection, then base / divider.
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = base_q;
    div_req.divisor  = requested_hz_i[BW-1:0] + 1'b1;
    load_out         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (at_or_above) begin
            state_d = ST_DONE;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_QUOT;
          end
        end
      end
      ST_QUOT: begin
        if (div_rsp.done) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        div_req.start   = 1'b1;
        div_req.divisor = {{(BW - DW){1'b0}}, sel_div};
        state_d         = ST_ACH;
      end
      ST_ACH: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);
  assign code_next   = div_q[DW-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      v3_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sdhcd_pkg::CFG_BASE_CLOCK: base_q <= cfg_data_i;
          sdhcd_pkg::CFG_SPEC_V3:    v3_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept && at_or_above) begin
      div_q <= DW'(1);
      ach_q <= base_q;
    end
    if (state_q == ST_SEL) begin
      div_q <= sel_div;
    end
    if (state_q == ST_ACH && div_rsp.done) begin
      ach_q <= div_rsp.quotient;
    end
    if (load_out) begin
      code_q    <= code_next;
      ach_out_q <= ach_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign divider_code_o       = code_q;
  assign clock_control_word_o = {code_q[7:0], code_q[9:8], 5'b00000, 1'b1};
  assign achieved_hz_o        = ach_out_q;

endmodule

// ===== hw/rtl/sdhcd_chk.sv =====
module sdhcd_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [sdhcd_pkg::CODE_W-1:0]    divider_code_o,
  input logic [sdhcd_pkg::WORD_W-1:0]    clock_control_word_o,
  input logic [sdhcd_pkg::BASE_W-1:0]    achieved_hz_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(divider_code_o)
      && $stable(clock_control_word_o) && $stable(achieved_hz_o))
    else $error("stalled result changed");

  // The block goes busy right after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request side not busy after a transaction");

  // The control word carries the code and the internal enable bit.
  a_word_packing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> clock_control_word_o[15:8] == divider_code_o[7:0]
      && clock_control_word_o[7:6] == divider_code_o[9:8]
      && clock_control_word_o[5:1] == 5'b00000 && clock_control_word_o[0])
    else $error("clock control word does not match divider code");

  // A new result only appears at the end of a busy period.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a computation");

endmodule

bind sd_host_clock_divider_top sdhcd_chk u_sdhcd_chk (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .divider_code_o       (divider_code_o),
  .clock_control_word_o (clock_control_word_o),
  .achieved_hz_o        (achieved_hz_o)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sdhcd_pkg::*;

  localparam int unsigned V3_CAP = 2046;
  localparam int unsigned LEGACY_CAP = 256;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 70;
  localparam int unsigned RESULT_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 86;
  localparam int unsigned MAX_REPORTS = 100;
  localparam logic [BASE_W-1:0] BASE_MAX = '1;

  // The index port is two bits wide, but only two registers exist. Writes to the
  // other two indexes must be dropped by the block.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  // One clock setting as the block reports it.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] word;
    logic [BASE_W-1:0] hz;
  } clock_setting_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [BASE_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [REQ_W-1:0]     requested_hz_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CODE_W-1:0]    divider_code_o;
  logic [WORD_W-1:0]    clock_control_word_o;
  logic [BASE_W-1:0]    achieved_hz_o;

  // Shadow copy of the configuration registers, updated on every write.
  logic [BASE_W-1:0] base_hz;
  logic              v3_mode;

  clock_setting_t expected_settings[$];

  int unsigned cycle_count;
  int unsigned n_settings_checked;
  int unsigned n_mismatches;
  int unsigned n_reg_writes;

  // Knobs shared between the test sequence and the result-side stall process.
  // A long result hold is asked for by raising the request count.
  bit input_burst;
  bit stall_free;
  int unsigned holds_requested;

  sd_host_clock_divider_top #(
    .V3_DIVIDER_CAP    (V3_CAP),
    .LEGACY_DIVIDER_CAP(LEGACY_CAP)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .requested_hz_i      (requested_hz_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .divider_code_o      (divider_code_o),
    .clock_control_word_o(clock_control_word_o),
    .achieved_hz_o       (achieved_hz_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  // The run is cut off here if the block stops moving.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d settings still expected", $time,
               cycle_count, expected_settings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Works out the divider that the block must choose for a request under the
  // current shadow configuration, and from it the three result fields.
  function automatic clock_setting_t predict_setting(input logic [REQ_W-1:0] req);
    int unsigned base;
    int unsigned div;
    logic [CODE_W-1:0] code;
    clock_setting_t s;
    base = 32'(base_hz);
    div = 1;
    if (req < base) begin
      if (v3_mode) begin
        // Smallest even divider whose floor quotient does not exceed the
        // request; the search gives up at the cap.
        div = 2;
        while (div < V3_CAP && base / div > req) div += 2;
      end else begin
        while (div < LEGACY_CAP && base / div > req) div = div << 1;
      end
    end
    code = CODE_W'(div >> 1);
    s.code = code;
    s.word = {code[7:0], code[9:8], 5'b00000, 1'b1};
    s.hz = BASE_W'(base / div);
    return s;
  endfunction

  // Most gaps are short; a few are long. A burst phase sends back to back.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (input_burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Requests are aimed mostly at the edges between candidate dividers, where
  // an off-by-one in the search or the compare would show.
  function automatic logic [REQ_W-1:0] pick_request();
    int unsigned base;
    int unsigned div;
    int unsigned sel;
    base = 32'(base_hz);
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      if (v3_mode) div = 2 * $urandom_range(1, V3_CAP / 2);
      else div = 1 << $urandom_range(0, 8);
      return base / div + $urandom_range(0, 2) - 1;
    end
    if (sel < 70) return $urandom;
    if (sel < 85) return $urandom_range(0, base);
    if (sel < 95) return base + $urandom_range(0, 4) - 2;
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return BASE_MAX;
      1: return 28'd255_000_000;
      2: return BASE_W'($urandom_range(1, 4000));
      3, 4: return BASE_W'($urandom);
      default: return BASE_W'($urandom_range(1_000_000, 255_000_000));
    endcase
  endfunction

  // Called at a falling edge with the block idle. The write lands at the next
  // rising edge; the enable then drops.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BASE_CLOCK) base_hz = data;
    else if (idx == CFG_SPEC_V3) v3_mode = data[0];
    n_reg_writes++;
    @(negedge clk_i);
  endtask

  // Offers one request, waits for the transaction, records the expected
  // setting and then idles the input for the given gap. With a zero gap valid
  // stays high so the next call continues without a bubble.
  task automatic send_request(input logic [REQ_W-1:0] req, input int unsigned gap);
    in_valid_i <= 1'b1;
    requested_hz_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    expected_settings.push_back(predict_setting(req));
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drops valid and waits until every expected setting has been checked.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_settings.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // The result side: random stall stretches, stall-free stretches, and one
  // long hold on request so that the block backs up into its input.
  initial begin : result_stall_gen
    int unsigned r;
    int unsigned run_len;
    int unsigned holds_served;
    holds_served = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_requested) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (RESULT_HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stall_free) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall_i <= 1'b0;
          run_len = $urandom_range(1, 16);
        end else if (r < 90) begin
          out_stall_i <= 1'b1;
          run_len = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          run_len = $urandom_range(20, 60);
        end
        repeat (run_len - 1) @(negedge clk_i);
      end
    end
  end

  // Every result transaction is compared with the oldest expected setting.
  always @(posedge clk_i) begin : check_settings
    clock_setting_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_settings.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected: code %0d, word 0x%04h, %0d Hz", $time,
                   divider_code_o, clock_control_word_o, achieved_hz_o);
      end else begin
        want = expected_settings.pop_front();
        n_settings_checked++;
        if (divider_code_o !== want.code) begin
          n_mismatches++;
          if (n_mismatches <= MAX_REPORTS)
            $display("%0t: divider_code expected %0d, actual %0d", $time, want.code,
                     divider_code_o);
        end
        if (clock_control_word_o !== want.word) begin
          n_mismatches++;
          if (n_mismatches <= MAX_REPORTS)
            $display("%0t: clock_control_word expected 0x%04h, actual 0x%04h", $time,
                     want.word, clock_control_word_o);
        end
        if (achieved_hz_o !== want.hz) begin
          n_mismatches++;
          if (n_mismatches <= MAX_REPORTS)
            $display("%0t: achieved_hz expected %0d, actual %0d", $time, want.hz,
                     achieved_hz_o);
        end
      end
    end
  end

  // With the reset configuration the base clock is zero, so nothing can be
  // below it: the divider is one and the achieved clock is zero.
  task automatic test_reset_defaults();
    send_request('0, pick_gap());
    send_request('1, pick_gap());
    drain_results();
  endtask

  // Power-of-two search around a 200 MHz base. The mode write carries junk in
  // the upper bits, which the block must ignore.
  task automatic test_legacy_directed();
    write_reg(CFG_BASE_CLOCK, 28'd200_000_000);
    write_reg(CFG_SPEC_V3, {27'($urandom), 1'b0});
    send_request(32'd0, pick_gap());           // no divider reaches it: the cap
    send_request(32'd400_000, pick_gap());     // still above at the cap
    send_request(32'd781_250, pick_gap());     // exactly base over the cap
    send_request(32'd100_000_000, pick_gap()); // exactly half
    send_request(32'd99_999_999, pick_gap());
    send_request(32'd199_999_999, pick_gap()); // just below the base
    send_request(32'd200_000_000, pick_gap()); // equal to the base
    send_request(32'd200_000_001, pick_gap());
    drain_results();
  endtask

  // Even-divider search around a 255 MHz base, including the search that
  // runs all the way to the cap and gives the all-ones code.
  task automatic test_v3_directed();
    write_reg(CFG_SPEC_V3, {27'($urandom), 1'b1});
    write_reg(CFG_BASE_CLOCK, 28'd255_000_000);
    send_request(32'd0, pick_gap());
    send_request(32'd124_633, pick_gap());
    send_request(32'd124_755, pick_gap());
    send_request(32'd127_500_000, pick_gap());
    send_request(32'd127_499_999, pick_gap());
    send_request(32'd254_999_999, pick_gap());
    send_request('1, pick_gap());
    drain_results();
  endtask

  // Largest and smallest non-zero base clock, and writes to the two indexes
  // that have no register behind them. Each write waits for the block to
  // finish its work.
  task automatic test_config_extremes();
    write_reg(CFG_BASE_CLOCK, BASE_MAX);
    send_request(32'd0, pick_gap());
    send_request(REQ_W'(BASE_MAX) - 1, pick_gap());
    drain_results();
    write_reg(CFG_UNUSED_2, BASE_W'($urandom));
    write_reg(CFG_UNUSED_3, BASE_MAX);
    write_reg(CFG_BASE_CLOCK, 28'd1);
    send_request(32'd0, pick_gap());
    drain_results();
    write_reg(CFG_SPEC_V3, 28'd0);
    send_request(32'd0, pick_gap());
    send_request(32'd1, pick_gap());
    drain_results();
  endtask

  // Random phases, each with its own configuration. The first two use the
  // largest base in both modes; some phases run with no idling at all.
  task automatic test_random_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                  BASE_W'($urandom));
      write_reg(CFG_BASE_CLOCK, (phase < 2) ? BASE_MAX : pick_base());
      write_reg(CFG_SPEC_V3, {27'($urandom), phase[0]});
      input_burst = ($urandom_range(0, 3) == 0);
      stall_free = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(pick_request(), pick_gap());
      drain_results();
    end
    input_burst = 1'b0;
    stall_free = 1'b0;
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the output register and the sequencer fill and the input stalls.
  task automatic test_backpressure();
    write_reg(CFG_BASE_CLOCK, 28'd50_000_000);
    write_reg(CFG_SPEC_V3, 28'd1);
    input_burst = 1'b1;
    holds_requested++;
    for (int n = 0; n < 16; n++) send_request(pick_request(), pick_gap());
    input_burst = 1'b0;
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_BASE_CLOCK;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    requested_hz_i = '0;
    base_hz = '0;
    v3_mode = 1'b0;
    n_reg_writes = 0;
    input_burst = 1'b0;
    stall_free = 1'b0;
    holds_requested = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_legacy_directed();
    test_v3_directed();
    test_config_extremes();
    test_random_phases();
    test_backpressure();

    // Leave room for anything the block might still emit unprompted.
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Checked %0d clock settings in both divider modes over %0d register writes,",
             n_settings_checked, n_reg_writes);
    $display("with random idling on both sides and one long result hold; %0d mismatches.",
             n_mismatches);
    if (n_mismatches == 0 && expected_settings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sdhcd_pkg.sv
hw/rtl/sdhcd_div.sv
hw/rtl/sd_host_clock_divider_top.sv
hw/rtl/sdhcd_chk.sv
verif/tb.sv
